[design/kbr_pkg.sv]
package kbr_pkg;

    localparam int KEY_W = 16;
    localparam int TIME_W = 32;
    localparam int OP_W = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_HOLD  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_TYPED_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;

    localparam logic [15:0] RESET_REPEAT_MS = 16'd100;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key_code;
        logic [TIME_W-1:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             queue_empty;
    } rsp_t;

endpackage

[design/key_buffer_with_typematic_repeat.sv]
// Keyboard FIFO of 16-bit key codes with a held-key repeater and a one-look read gate.
// A command is taken at every clock edge where start is high; busy stays low, so one
// command can be issued in every cycle. Its result beat appears on result with done
// high for exactly one cycle, the cycle right after the command was taken, and must be
// captured then since the receiver cannot stall the block. The FIFO entries sit in a
// memory with one write port and one read port, and the head entry is read ahead into
// a register every cycle, which is what lets a pop or peek return the head key from that register.
// Configuration writes take effect at the edge where cfg_we is high and should only be
// issued with no command in flight.
module key_buffer_with_typematic_repeat #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  kbr_pkg::cmd_t                     cmd,
    output logic                              done,
    output kbr_pkg::rsp_t                     result,
    input  logic                              cfg_we,
    input  logic [kbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kbr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kbr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

    logic [KEY_W-1:0] key_store [QUEUE_DEPTH];
    logic [KEY_W-1:0] head_data_reg;

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              gate_reg, gate_next;
    logic [KEY_W-1:0]  held_reg, held_next;
    logic [TIME_W-1:0] due_reg, due_next;
    logic              typed_reg, typed_next;
    logic [15:0]       period_reg, period_next;
    logic              done_reg;
    rsp_t              result_reg, result_next;

    logic              accept;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW:0]       wr_sum;
    logic [AW:0]       head_inc;
    logic [TIME_W-1:0] due_diff;
    logic              due_now;
    logic [KEY_W-1:0]  due_key;
    logic              due_neg_next;

    assign accept = start && !busy;
    assign busy = 1'b0;
    assign done = done_reg;
    assign result = result_reg;

    assign wr_sum = {1'b0, head_reg} + {1'b0, fill_reg[AW-1:0]};
    assign wr_addr = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];
    assign head_inc = {1'b0, head_reg} + (AW + 1)'(1);

    assign due_diff = cmd.now_ms - due_reg;
    assign due_now = (held_reg != '0) && !due_diff[TIME_W-1];
    assign due_key = due_now ? held_reg : '0;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        gate_next = gate_reg;
        held_next = held_reg;
        due_next = due_reg;
        typed_next = typed_reg;
        period_next = period_reg;
        wr_en = 1'b0;
        due_neg_next = due_diff[TIME_W-1];
        result_next.key_out = '0;

        if (accept)
        begin
            case (cmd.op)
                OP_PUSH:
                begin
                    if (cmd.key_code != '0 && fill_reg < DEPTH_C)
                    begin
                        wr_en = 1'b1;
                        fill_next = fill_reg + CW'(1);
                        gate_next = 1'b0;
                    end
                end
                OP_PEEK:
                begin
                    if (gate_reg)
                    begin
                        gate_next = 1'b0;
                    end
                    else if (fill_reg != '0)
                    begin
                        result_next.key_out = head_data_reg;
                    end
                    else
                    begin
                        result_next.key_out = due_key;
                    end
                end
                OP_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.key_out = due_key;
                        if (due_now)
                        begin
                            due_next = cmd.now_ms + {16'd0, period_reg};
                            due_neg_next = (period_reg != '0);
                            gate_next = typed_reg;
                        end
                        else
                        begin
                            gate_next = 1'b0;
                        end
                    end
                    else
                    begin
                        result_next.key_out = head_data_reg;
                        head_next = (head_inc == DEPTH_W) ? '0 : head_inc[AW-1:0];
                        fill_next = fill_reg - CW'(1);
                        gate_next = typed_reg;
                    end
                end
                OP_CLEAR:
                begin
                    head_next = '0;
                    fill_next = '0;
                    gate_next = 1'b0;
                    held_next = '0;
                end
                OP_HOLD:
                begin
                    held_next = cmd.key_code;
                    due_next = cmd.now_ms;
                    due_neg_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        result_next.queue_empty = (fill_next == '0) && !((held_next != '0) && !due_neg_next);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TYPED_MODE:
                begin
                    typed_next = cfg_data[0];
                    gate_next = 1'b0;
                end
                CFG_REPEAT_PERIOD:
                begin
                    period_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            gate_reg <= 1'b0;
            held_reg <= '0;
            due_reg <= '0;
            typed_reg <= 1'b0;
            period_reg <= RESET_REPEAT_MS;
            done_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            gate_reg <= gate_next;
            held_reg <= held_next;
            due_reg <= due_next;
            typed_reg <= typed_next;
            period_reg <= period_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // The head entry is read ahead every cycle, with a bypass when this cycle's
    // push lands on the new head address.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_store[wr_addr] <= cmd.key_code;
        end
        if (wr_en && wr_addr == head_next)
        begin
            head_data_reg <= cmd.key_code;
        end
        else
        begin
            head_data_reg <= key_store[head_next];
        end
    end

endmodule

[design/kbr_checker.sv]
module kbr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input kbr_pkg::cmd_t cmd,
    input logic          done,
    input kbr_pkg::rsp_t result
);
    import kbr_pkg::*;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (done == $past(start && !busy)))
        else $error("result beat does not match the accepted command");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_CLEAR)
        |=> (done && result.key_out == '0 && result.queue_empty))
        else $error("clear did not leave the buffer empty");

    a_push_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.op == OP_PUSH || cmd.op == OP_HOLD))
        |=> (result.key_out == '0))
        else $error("push or hold returned a key");

endmodule

bind key_buffer_with_typematic_repeat kbr_checker u_kbr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

[sim/key_buffer_checker.sv]
module key_buffer_checker #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  kbr_pkg::cmd_t                   cmd,
    input  logic                            done,
    input  kbr_pkg::rsp_t                   result,
    input  logic                            cfg_we,
    input  logic [kbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import kbr_pkg::*;

    logic [KEY_W-1:0]  key_store [QUEUE_DEPTH];
    int                head_slot;
    int                fill_level;
    logic              gate_closed;
    logic              typed_on;
    logic [15:0]       repeat_ms;
    logic [KEY_W-1:0]  hold_code;
    logic [TIME_W-1:0] held_due;
    rsp_t              expected_rsp_q [$];

    function automatic logic [KEY_W-1:0] hold_code_due(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] lag;
        lag = now - held_due;
        if (hold_code == '0 || lag[TIME_W-1])
        begin
            return '0;
        end
        return hold_code;
    endfunction

    task automatic apply_key_command(input cmd_t beat, output rsp_t rsp);
        logic [KEY_W-1:0] key_seen;
        key_seen = '0;
        case (beat.op)
            OP_PUSH:
            begin
                if (beat.key_code != '0 && fill_level < QUEUE_DEPTH)
                begin
                    key_store[(head_slot + fill_level) % QUEUE_DEPTH] = beat.key_code;
                    fill_level++;
                    gate_closed = 1'b0;
                end
            end
            OP_PEEK:
            begin
                if (gate_closed)
                begin
                    gate_closed = 1'b0;
                end
                else if (fill_level > 0)
                begin
                    key_seen = key_store[head_slot];
                end
                else
                begin
                    key_seen = hold_code_due(beat.now_ms);
                end
            end
            OP_POP:
            begin
                if (fill_level == 0)
                begin
                    key_seen = hold_code_due(beat.now_ms);
                    if (key_seen != '0)
                    begin
                        held_due = beat.now_ms + TIME_W'(repeat_ms);
                        gate_closed = typed_on;
                    end
                    else
                    begin
                        gate_closed = 1'b0;
                    end
                end
                else
                begin
                    key_seen = key_store[head_slot];
                    head_slot = (head_slot + 1) % QUEUE_DEPTH;
                    fill_level--;
                    gate_closed = typed_on;
                end
            end
            OP_CLEAR:
            begin
                head_slot = 0;
                fill_level = 0;
                gate_closed = 1'b0;
                hold_code = '0;
            end
            OP_HOLD:
            begin
                hold_code = beat.key_code;
                held_due = beat.now_ms;
            end
            default:
            begin
            end
        endcase
        rsp.key_out = key_seen;
        rsp.queue_empty = (fill_level == 0 && hold_code_due(beat.now_ms) == '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t predicted;
        rsp_t oldest;
        if (!rst_n)
        begin
            head_slot = 0;
            fill_level = 0;
            gate_closed = 1'b0;
            typed_on = 1'b0;
            repeat_ms = RESET_REPEAT_MS;
            hold_code = '0;
            held_due = '0;
            expected_rsp_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TYPED_MODE)
                begin
                    typed_on = cfg_data[0];
                    gate_closed = 1'b0;
                end
                else if (cfg_index == CFG_REPEAT_PERIOD)
                begin
                    repeat_ms = cfg_data;
                end
            end
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_rsp_q.pop_front();
                    if (result.key_out !== oldest.key_out)
                    begin
                        $error("key_out expected %h actual %h", oldest.key_out, result.key_out);
                        fail_count++;
                    end
                    if (result.queue_empty !== oldest.queue_empty)
                    begin
                        $error("queue_empty expected %b actual %b",
                               oldest.queue_empty, result.queue_empty);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_key_command(cmd, predicted);
                expected_rsp_q.push_back(predicted);
            end
            pending = expected_rsp_q.size();
        end
    end

endmodule

[sim/tb_key_buffer_with_typematic_repeat.sv]
module tb_key_buffer_with_typematic_repeat;
    import kbr_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    localparam int ITEM_TARGET   = 1650;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [OP_W-1:0]        OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]        OP_SPARE_HI  = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    cmd_t                   cmd;
    logic                   done;
    rsp_t                   result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     pending;
    int                     cycles;
    int                     sent;
    logic                   took;
    logic                   idle_on;
    logic [TIME_W-1:0]      clock_ms;
    logic [15:0]            cur_period;

    key_buffer_with_typematic_repeat #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    key_buffer_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        took <= start && !busy;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] nonzero_key();
        logic [KEY_W-1:0] k;
        do
        begin
            k = KEY_W'($urandom);
        end
        while (k == '0);
        return k;
    endfunction

    task automatic pace();
        int roll;
        int gap;
        gap = 0;
        if (idle_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
            begin
                gap = $urandom_range(8, 30);
            end
            else if (roll >= 70)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic issue(input logic [OP_W-1:0] code, input logic [KEY_W-1:0] key);
        cmd_t beat;
        pace();
        beat.op = code;
        beat.key_code = key;
        beat.now_ms = clock_ms;
        cmd <= beat;
        start <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (!took);
        sent++;
    endtask

    task automatic tick(input int max_ms);
        clock_ms = clock_ms + TIME_W'($urandom_range(0, max_ms));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data <= data;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic typed, input logic [15:0] period);
        logic [CFG_DATA_W-1:0] mode_word;
        drain();
        mode_word = CFG_DATA_W'($urandom);
        mode_word[0] = typed;
        write_reg(CFG_TYPED_MODE, mode_word);
        write_reg(CFG_REPEAT_PERIOD, period);
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
        cur_period = period;
    endtask

    task automatic fill_burst();
        repeat ($urandom_range(QUEUE_DEPTH - 4, QUEUE_DEPTH + 6))
        begin
            tick(5);
            issue(OP_PUSH, nonzero_key());
        end
        repeat ($urandom_range(0, QUEUE_DEPTH + 6))
        begin
            tick(5);
            issue(($urandom_range(0, 4) == 0) ? OP_PEEK : OP_POP, KEY_W'($urandom));
        end
    endtask

    task automatic typing_run();
        int roll;
        repeat ($urandom_range(1, 5))
        begin
            tick(30);
            issue(OP_PUSH, nonzero_key());
        end
        repeat ($urandom_range(1, 8))
        begin
            tick(30);
            roll = $urandom_range(0, 9);
            if (roll < 2)
            begin
                issue(OP_PUSH, nonzero_key());
            end
            else if (roll < 5)
            begin
                issue(OP_PEEK, KEY_W'($urandom));
            end
            else
            begin
                issue(OP_POP, KEY_W'($urandom));
            end
        end
    endtask

    task automatic held_run();
        int roll;
        tick(50);
        issue(OP_HOLD, nonzero_key());
        repeat ($urandom_range(3, 12))
        begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, int'(cur_period) * 3 / 2 + 1));
            issue(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP, KEY_W'($urandom));
        end
        roll = $urandom_range(0, 2);
        if (roll == 0)
        begin
            issue(OP_HOLD, '0);
        end
        else if (roll == 1)
        begin
            issue(OP_CLEAR, KEY_W'($urandom));
        end
    endtask

    task automatic noise_run();
        logic [KEY_W-1:0] key;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                clock_ms = $urandom;
            end
            else
            begin
                tick(200);
            end
            key = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom);
            issue(OP_W'($urandom_range(OP_PUSH, OP_SPARE_HI)), key);
        end
    endtask

    initial
    begin
        int stop_at;
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent = 0;
        idle_on = 1'b0;
        clock_ms = 10;
        cur_period = RESET_REPEAT_MS;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(OP_POP, '0);
        issue(OP_PEEK, '0);
        issue(OP_PUSH, '0);
        issue(OP_PUSH, 16'hFFFF);
        issue(OP_PUSH, 16'h0001);
        issue(OP_PEEK, '0);
        issue(OP_POP, '0);
        issue(OP_POP, '0);
        clock_ms = 1000;
        issue(OP_HOLD, 16'h8000);
        issue(OP_PEEK, '0);
        issue(OP_POP, '0);
        clock_ms = 1050;
        issue(OP_POP, '0);
        clock_ms = 1100;
        issue(OP_POP, '0);
        issue(OP_HOLD, '0);
        issue(OP_POP, '0);
        issue(OP_SPARE_LO, 16'hFFFF);
        issue(OP_SPARE_HI, 16'hFFFF);
        clock_ms = 32'hFFFF_FFF0;
        issue(OP_HOLD, 16'h1234);
        clock_ms = 32'h0000_0010;
        issue(OP_POP, '0);
        clock_ms = 32'h8000_0080;
        issue(OP_PEEK, '0);
        issue(OP_CLEAR, '0);

        configure(1'b1, 16'd0);
        issue(OP_PUSH, 16'h1E61);
        issue(OP_POP, '0);
        issue(OP_PEEK, '0);
        issue(OP_PUSH, 16'h3062);
        issue(OP_POP, '0);
        issue(OP_PUSH, 16'h2E63);
        issue(OP_PEEK, '0);
        issue(OP_HOLD, 16'h2064);
        issue(OP_POP, '0);
        issue(OP_POP, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure(1'b0, 16'd1);
                1: configure(1'b1, 16'hFFFF);
                2: configure(1'b0, RESET_REPEAT_MS);
                3: configure(1'b1, 16'd1);
                default: configure($urandom_range(0, 1) == 1,
                                   ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 300))
                                                               : 16'($urandom_range(1, 65535)));
            endcase
            stop_at = sent + ITEM_TARGET / PHASES;
            while (sent < stop_at)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                roll = $urandom_range(0, 9);
                if (roll == 0)
                begin
                    fill_burst();
                end
                else if (roll < 5)
                begin
                    typing_run();
                end
                else if (roll < 8)
                begin
                    held_run();
                end
                else
                begin
                    noise_run();
                end
            end
        end

        drain();
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
design/kbr_pkg.sv
design/key_buffer_with_typematic_repeat.sv
design/kbr_checker.sv
sim/key_buffer_checker.sv
sim/tb_key_buffer_with_typematic_repeat.sv
